>>> design/trhc_pkg.sv
// ----------------------------------------------------------------------------
// trhc_pkg: shared widths, constants and types
// Fixed-point formats and sideband types for the two-ray heading datapath.
// ----------------------------------------------------------------------------
package trhc_pkg;

    localparam int DIST_BITS  = 12;                // range reading width, mm
    localparam int ANG_W      = 14;                // sensor angle register
    localparam int MAG_W      = 15;                // angle magnitude 0..18000
    localparam int OUT_W      = 16;                // signed turn angle
    localparam int COS_W      = 32;                // signed Q30 cosine
    localparam int QF         = 30;                // Q30 fraction bits
    localparam int RATIO_W    = QF + 1;            // 0..1.0 in Q30

    localparam int LR_W       = 2 * DIST_BITS;     // product of two readings
    localparam int SUM_W      = LR_W + 1;          // L^2 + R^2
    localparam int C2_W       = LR_W + 18;         // third side squared, Q16
    localparam int ROOT_W     = C2_W / 2;          // third side, Q8
    localparam int NUM_W      = C2_W + 1;
    localparam int DEN_W      = C2_W;

    localparam int COS_LAT    = 21;                // cosine pipeline depth
    localparam int ACOS_STEPS = 15;                // search levels over 0..18000
    localparam int WARM_W     = $clog2(COS_LAT + 2);

    localparam logic [RATIO_W-1:0] Q_ONE        = RATIO_W'(1) << QF;
    localparam logic [ANG_W-1:0]   ANGLE_RESET  = ANG_W'(4500);
    localparam logic [MAG_W-1:0]   HALF_TURN    = MAG_W'(18000);
    localparam logic [MAG_W-1:0]   QUARTER_TURN = MAG_W'(9000);

    typedef struct packed {
        logic valid;
        logic swap;     // right reading is the longer one
        logic zero;     // both readings zero
        logic degen;    // third side is zero
    } t_side;

    typedef struct packed {
        logic [C2_W-1:0]      c2;
        logic [DIST_BITS-1:0] lng;
        logic [LR_W-1:0]      lng2;
        logic [LR_W-1:0]      sht2;
    } t_geo;

endpackage

>>> design/two_ray_heading_correction.sv
// ----------------------------------------------------------------------------
// two_ray_heading_correction: heading correction from two ray ranges
// Start a beat with i_start while o_busy is low; the result appears on
// o_turn_angle/o_degenerate with o_valid high for one cycle. A new beat may
// start every cycle while o_busy is low; latency is set by the fifteen-level
// arc cosine search, each level waiting on its cosine pipeline, plus the
// square root and Q30 divide pipelines. Results cannot be held off and must
// be taken when o_valid is high. After reset and after each sensor angle
// write, o_busy stays high while the apex cosine is recomputed; write the
// angle only when no beat is in flight.
// ----------------------------------------------------------------------------
module two_ray_heading_correction (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    output logic                                o_busy,
    input  logic [trhc_pkg::DIST_BITS-1:0]      i_left_distance,
    input  logic [trhc_pkg::DIST_BITS-1:0]      i_right_distance,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [trhc_pkg::ANG_W-1:0]          i_sensor_angle,
    output logic                                o_valid,
    output logic signed [trhc_pkg::OUT_W-1:0]   o_turn_angle,
    output logic                                o_degenerate
);

    localparam int DB  = trhc_pkg::DIST_BITS;
    localparam int LW  = trhc_pkg::LR_W;
    localparam int CW  = trhc_pkg::COS_W;
    localparam int C2W = trhc_pkg::C2_W;
    localparam int MAGW = LW + CW - 1;

    // configuration and apex cosine
    logic [trhc_pkg::ANG_W-1:0]    r_angle;
    logic [trhc_pkg::WARM_W-1:0]   r_warm;
    logic                          r_cfg_rdy;
    logic signed [CW-1:0]          r_apex;
    logic signed [CW-1:0]          s_apex;
    logic [trhc_pkg::MAG_W:0]      s_two_ang;
    logic [trhc_pkg::MAG_W-1:0]    s_apex_ang;
    logic                          s_cfg_wr;
    logic                          s_accept;

    assign s_cfg_wr    = i_cfg_valid && o_cfg_ready;
    assign s_accept    = i_start && !o_busy;
    assign o_busy      = r_warm != '0;
    assign o_cfg_ready = r_cfg_rdy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_angle   <= trhc_pkg::ANGLE_RESET;
            r_warm    <= trhc_pkg::WARM_W'(trhc_pkg::COS_LAT + 1);
            r_cfg_rdy <= 1'b0;
        end else begin
            r_cfg_rdy <= 1'b1;
            if (s_cfg_wr) begin
                r_angle <= i_sensor_angle;
                r_warm  <= trhc_pkg::WARM_W'(trhc_pkg::COS_LAT + 1);
            end else if (r_warm != '0) begin
                r_warm <= r_warm - trhc_pkg::WARM_W'(1);
            end
        end
    end

    // |180 - 2*angle|, cosine is even
    always_comb begin
        s_two_ang = {1'b0, r_angle, 1'b0};
        if (r_angle <= 14'(trhc_pkg::QUARTER_TURN)) begin
            s_apex_ang = trhc_pkg::MAG_W'((trhc_pkg::MAG_W+1)'(trhc_pkg::HALF_TURN) - s_two_ang);
        end else begin
            s_apex_ang = trhc_pkg::MAG_W'(s_two_ang - (trhc_pkg::MAG_W+1)'(trhc_pkg::HALF_TURN));
        end
    end

    trhc_cos u_apex_cos (
        .i_clk   (i_clk),
        .i_angle (s_apex_ang),
        .o_cos   (s_apex)
    );

    always_ff @(posedge i_clk) begin
        r_apex <= s_apex;
    end

    // front: squares, products, third side squared
    logic [DB-1:0]          r_in_l, r_in_r;
    logic                   r_in_vld;
    logic [LW-1:0]          r1_lr;
    logic [trhc_pkg::SUM_W-1:0] r1_sum;
    logic [DB-1:0]          r1_lng;
    logic [LW-1:0]          r1_lng2, r1_sht2;
    trhc_pkg::t_side        r1_side;
    logic [C2W-1:0]         r2_tab;
    logic                   r2_cneg;
    logic [trhc_pkg::SUM_W-1:0] r2_sum;
    logic [DB-1:0]          r2_lng;
    logic [LW-1:0]          r2_lng2, r2_sht2;
    trhc_pkg::t_side        r2_side;
    trhc_pkg::t_geo         r3_geo;
    trhc_pkg::t_side        r3_side;

    logic [LW-1:0]          s_ll, s_rr;
    logic                   s_swap;
    logic [CW-2:0]          s_cabs;
    logic [MAGW-1:0]        s_mag;
    logic signed [C2W+1:0]  s_c2;

    always_comb begin
        s_ll   = LW'(r_in_l) * LW'(r_in_l);
        s_rr   = LW'(r_in_r) * LW'(r_in_r);
        s_swap = r_in_r > r_in_l;
        s_cabs = r_apex[CW-1] ? (CW-1)'(-r_apex) : r_apex[CW-2:0];
        s_mag  = MAGW'(r1_lr) * MAGW'(s_cabs) + MAGW'(4096);
        s_c2   = $signed({1'b0, (C2W+1)'(r2_sum) << 16});
        if (r2_cneg) begin
            s_c2 = s_c2 + $signed({2'b00, r2_tab});
        end else begin
            s_c2 = s_c2 - $signed({2'b00, r2_tab});
        end
    end

    always_ff @(posedge i_clk) begin
        r_in_l  <= i_left_distance;
        r_in_r  <= i_right_distance;

        r1_lr   <= LW'(r_in_l) * LW'(r_in_r);
        r1_sum  <= trhc_pkg::SUM_W'(s_ll) + trhc_pkg::SUM_W'(s_rr);
        r1_lng  <= s_swap ? r_in_r : r_in_l;
        r1_lng2 <= s_swap ? s_rr : s_ll;
        r1_sht2 <= s_swap ? s_ll : s_rr;

        r2_tab  <= C2W'(s_mag >> 13);
        r2_cneg <= r_apex[CW-1];
        r2_sum  <= r1_sum;
        r2_lng  <= r1_lng;
        r2_lng2 <= r1_lng2;
        r2_sht2 <= r1_sht2;

        r3_geo.c2   <= s_c2[C2W+1] ? '0 : C2W'(s_c2);
        r3_geo.lng  <= r2_lng;
        r3_geo.lng2 <= r2_lng2;
        r3_geo.sht2 <= r2_sht2;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
            r1_side  <= '0;
            r2_side  <= '0;
            r3_side  <= '0;
        end else begin
            r_in_vld      <= s_accept;
            r1_side.valid <= r_in_vld;
            r1_side.swap  <= s_swap;
            r1_side.zero  <= (r_in_l == '0) && (r_in_r == '0);
            r1_side.degen <= 1'b0;
            r2_side       <= r1_side;
            r3_side       <= r2_side;
        end
    end

    // third side
    trhc_pkg::t_side               s_q_side;
    trhc_pkg::t_geo                s_q_geo;
    logic [trhc_pkg::ROOT_W-1:0]   s_root;

    trhc_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_side  (r3_side),
        .i_geo   (r3_geo),
        .o_side  (s_q_side),
        .o_geo   (s_q_geo),
        .o_root  (s_root)
    );

    // cosine of the angle at the longer reading's end, as num/den
    logic [trhc_pkg::NUM_W-1:0] r4_num;
    logic [trhc_pkg::DEN_W-1:0] r4_den;
    trhc_pkg::t_side            r4_side;

    always_ff @(posedge i_clk) begin
        r4_num <= (trhc_pkg::NUM_W'(s_q_geo.lng2) << 16) + trhc_pkg::NUM_W'(s_q_geo.c2)
                  - (trhc_pkg::NUM_W'(s_q_geo.sht2) << 16);
        r4_den <= (trhc_pkg::DEN_W'(s_q_geo.lng) * trhc_pkg::DEN_W'(s_root)) << 9;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_side <= '0;
        end else begin
            r4_side <= {s_q_side.valid, s_q_side.swap, s_q_side.zero,
                        !s_q_side.zero && (s_root == '0)};
        end
    end

    trhc_pkg::t_side               s_d_side;
    logic [trhc_pkg::RATIO_W-1:0]  s_ratio;

    trhc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_side  (r4_side),
        .i_num   (r4_num),
        .i_den   (r4_den),
        .o_side  (s_d_side),
        .o_ratio (s_ratio)
    );

    trhc_pkg::t_side               s_a_side;
    logic [trhc_pkg::MAG_W-1:0]    s_theta;

    trhc_acos u_acos (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_side  (s_d_side),
        .i_ratio (s_ratio),
        .o_side  (s_a_side),
        .o_theta (s_theta)
    );

    // result
    logic signed [trhc_pkg::OUT_W-1:0] s_diff;
    logic signed [trhc_pkg::OUT_W-1:0] s_res;
    logic signed [trhc_pkg::OUT_W-1:0] r_res;
    logic                              r_degen;
    logic                              r_vld;

    always_comb begin
        s_diff = $signed(trhc_pkg::OUT_W'(r_angle)) - $signed(trhc_pkg::OUT_W'(s_theta));
        s_res  = s_a_side.swap ? -s_diff : s_diff;
        if (s_a_side.zero || s_a_side.degen) begin
            s_res = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res   <= s_res;
        r_degen <= s_a_side.degen;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= s_a_side.valid;
        end
    end

    assign o_valid      = r_vld;
    assign o_turn_angle = r_res;
    assign o_degenerate = r_degen;

`ifndef SYNTHESIS
    a_degen_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_degenerate |-> o_turn_angle == '0)
        else $error("degenerate result with nonzero turn angle");

    a_turn_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_turn_angle >= -16'sd18000) && (o_turn_angle <= 16'sd18000))
        else $error("turn angle out of range");

    a_cfg_busy : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_valid && o_cfg_ready |=> o_busy)
        else $error("angle write did not hold off new beats");
`endif

endmodule

>>> design/trhc_cos.sv
// ----------------------------------------------------------------------------
// trhc_cos: pipelined Q30 cosine
// Cosine of 0..18000 hundredths of a degree, degree-12 Horner series on the
// angle folded to the first quadrant.
// ----------------------------------------------------------------------------
module trhc_cos (
    input  logic                               i_clk,
    input  logic [trhc_pkg::MAG_W-1:0]         i_angle,
    output logic signed [trhc_pkg::COS_W-1:0]  o_cos
);

    localparam int NSTEP = 5;
    localparam int RW    = trhc_pkg::RATIO_W;
    localparam logic [17:0] PI_HI     = 18'd187403;   // pi_Q30 / 18000, integer part
    localparam logic [12:0] PI_LO     = 13'd5426;     // pi_Q30 mod 18000
    localparam logic [17:0] RECIP_18K = 18'd238609;   // floor(2^32 / 18000)
    localparam logic [14:0] DIV_18K   = 15'd18000;
    localparam logic [7:0]  DENS   [NSTEP] = '{8'd132, 8'd90, 8'd56, 8'd30, 8'd12};
    localparam logic [31:0] RECIPS [NSTEP] = '{32'd32537631, 32'd47721858, 32'd76695844,
                                               32'd143165576, 32'd357913941};

    logic        s_neg;
    logic [13:0] s_fold;

    logic        r0_neg, r1_neg, r2_neg, r3_neg;
    logic [25:0] r0_v, r1_v;
    logic [30:0] r0_p, r1_p, r2_x;
    logic [11:0] r1_qa;
    logic [31:0] r3_x2;

    logic [25:0] s_rem;
    logic [11:0] s_q;

    logic [31:0]   r_a_p   [NSTEP];
    logic [31:0]   r_a_x2  [NSTEP];
    logic          r_a_neg [NSTEP];
    logic [31:0]   r_b_p   [NSTEP];
    logic [31:0]   r_b_q   [NSTEP];
    logic [31:0]   r_b_x2  [NSTEP];
    logic          r_b_neg [NSTEP];
    logic [RW-1:0] r_c_t   [NSTEP];
    logic [31:0]   r_c_x2  [NSTEP];
    logic          r_c_neg [NSTEP];

    logic [31:0]                      r_f_p;
    logic                             r_f_neg;
    logic signed [trhc_pkg::COS_W:0]  s_c;
    logic signed [trhc_pkg::COS_W-1:0] r_out;

    always_comb begin
        s_neg  = i_angle > trhc_pkg::QUARTER_TURN;
        s_fold = s_neg ? 14'(trhc_pkg::HALF_TURN - i_angle) : i_angle[13:0];
    end

    // radians: m*pi/18000 rounded, split so the divide is on a narrow value
    always_ff @(posedge i_clk) begin
        r0_neg <= s_neg;
        r0_v   <= 26'(s_fold) * 26'(PI_LO) + 26'd9000;
        r0_p   <= 31'(s_fold) * 31'(PI_HI);
        r1_neg <= r0_neg;
        r1_v   <= r0_v;
        r1_p   <= r0_p;
        r1_qa  <= 12'((44'(r0_v) * 44'(RECIP_18K)) >> 32);
    end

    always_comb begin
        s_rem = r1_v - 26'(r1_qa) * 26'(DIV_18K);
        s_q   = r1_qa + 12'(s_rem >= 26'(DIV_18K));
    end

    always_ff @(posedge i_clk) begin
        r2_neg <= r1_neg;
        r2_x   <= r1_p + 31'(s_q);
        r3_neg <= r2_neg;
        r3_x2  <= 32'((62'(r2_x) * 62'(r2_x)) >> trhc_pkg::QF);
    end

    for (genvar k = 0; k < NSTEP; k++) begin : g_step
        logic [31:0]   s_x2;
        logic [RW-1:0] s_t;
        logic          s_n;
        logic [31:0]   s_r;
        logic [31:0]   s_qq;

        if (k == 0) begin : g_first
            assign s_x2 = r3_x2;
            assign s_t  = trhc_pkg::Q_ONE;
            assign s_n  = r3_neg;
        end else begin : g_next
            assign s_x2 = r_c_x2[k-1];
            assign s_t  = r_c_t[k-1];
            assign s_n  = r_c_neg[k-1];
        end

        always_comb begin
            s_r  = r_b_p[k] - 32'(r_b_q[k]) * 32'(DENS[k]);
            s_qq = r_b_q[k] + 32'(s_r >= 32'(DENS[k]));
        end

        // t = 1 - (x2*t)/den, divide by reciprocal with one correction
        always_ff @(posedge i_clk) begin
            r_a_p[k]   <= 32'((64'(s_x2) * 64'(s_t)) >> trhc_pkg::QF);
            r_a_x2[k]  <= s_x2;
            r_a_neg[k] <= s_n;
            r_b_p[k]   <= r_a_p[k];
            r_b_q[k]   <= 32'((64'(r_a_p[k]) * 64'(RECIPS[k])) >> 32);
            r_b_x2[k]  <= r_a_x2[k];
            r_b_neg[k] <= r_a_neg[k];
            r_c_t[k]   <= trhc_pkg::Q_ONE - RW'(s_qq);
            r_c_x2[k]  <= r_b_x2[k];
            r_c_neg[k] <= r_b_neg[k];
        end
    end

    assign s_c = $signed({2'b00, trhc_pkg::Q_ONE}) - $signed({2'b00, r_f_p[31:1]});

    always_ff @(posedge i_clk) begin
        r_f_p   <= 32'((64'(r_c_x2[NSTEP-1]) * 64'(r_c_t[NSTEP-1])) >> trhc_pkg::QF);
        r_f_neg <= r_c_neg[NSTEP-1];
        r_out   <= r_f_neg ? trhc_pkg::COS_W'(-s_c) : trhc_pkg::COS_W'(s_c);
    end

    assign o_cos = r_out;

endmodule

>>> design/trhc_isqrt.sv
// ----------------------------------------------------------------------------
// trhc_isqrt: pipelined floor square root
// One root bit per stage, restoring remainder method. Carries the geometry
// beat and sideband alongside.
// ----------------------------------------------------------------------------
module trhc_isqrt (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  trhc_pkg::t_side               i_side,
    input  trhc_pkg::t_geo                i_geo,
    output trhc_pkg::t_side               o_side,
    output trhc_pkg::t_geo                o_geo,
    output logic [trhc_pkg::ROOT_W-1:0]   o_root
);

    localparam int NR = trhc_pkg::ROOT_W;
    localparam int RW = NR + 2;

    logic [RW-1:0]    r_rem  [NR];
    logic [NR-1:0]    r_root [NR];
    trhc_pkg::t_geo   r_geo  [NR];
    trhc_pkg::t_side  r_side [NR];

    for (genvar k = 0; k < NR; k++) begin : g_bit
        logic [RW-1:0]   s_rem;
        logic [NR-1:0]   s_root;
        trhc_pkg::t_geo  s_geo;
        trhc_pkg::t_side s_side;
        logic [RW+1:0]   s_sh;
        logic [RW+1:0]   s_trial;

        if (k == 0) begin : g_first
            assign s_rem  = '0;
            assign s_root = '0;
            assign s_geo  = i_geo;
            assign s_side = i_side;
        end else begin : g_next
            assign s_rem  = r_rem[k-1];
            assign s_root = r_root[k-1];
            assign s_geo  = r_geo[k-1];
            assign s_side = r_side[k-1];
        end

        assign s_sh    = {s_rem, s_geo.c2[trhc_pkg::C2_W-1-2*k -: 2]};
        assign s_trial = (RW+2)'({s_root, 2'b01});

        always_ff @(posedge i_clk) begin
            r_geo[k] <= s_geo;
            if (s_sh >= s_trial) begin
                r_rem[k]  <= RW'(s_sh - s_trial);
                r_root[k] <= {s_root[NR-2:0], 1'b1};
            end else begin
                r_rem[k]  <= RW'(s_sh);
                r_root[k] <= {s_root[NR-2:0], 1'b0};
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_side[k] <= '0;
            end else begin
                r_side[k] <= s_side;
            end
        end
    end

    assign o_side = r_side[NR-1];
    assign o_geo  = r_geo[NR-1];
    assign o_root = r_root[NR-1];

endmodule

>>> design/trhc_div.sv
// ----------------------------------------------------------------------------
// trhc_div: pipelined Q30 ratio
// num/den truncated to Q30, saturated at 1.0. One quotient bit per stage.
// ----------------------------------------------------------------------------
module trhc_div (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  trhc_pkg::t_side                i_side,
    input  logic [trhc_pkg::NUM_W-1:0]     i_num,
    input  logic [trhc_pkg::DEN_W-1:0]     i_den,
    output trhc_pkg::t_side                o_side,
    output logic [trhc_pkg::RATIO_W-1:0]   o_ratio
);

    localparam int DW = trhc_pkg::DEN_W;
    localparam int NQ = trhc_pkg::QF;

    logic [DW-1:0]   r_rem  [NQ+1];
    logic [DW-1:0]   r_den  [NQ+1];
    logic [NQ-1:0]   r_q    [NQ+1];
    logic            r_sat  [NQ+1];
    trhc_pkg::t_side r_side [NQ+1];

    logic s_sat;
    assign s_sat = i_num >= trhc_pkg::NUM_W'(i_den);

    always_ff @(posedge i_clk) begin
        r_sat[0] <= s_sat;
        r_rem[0] <= s_sat ? '0 : DW'(i_num);
        r_den[0] <= i_den;
        r_q[0]   <= '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side[0] <= '0;
        end else begin
            r_side[0] <= i_side;
        end
    end

    for (genvar k = 1; k <= NQ; k++) begin : g_bit
        logic [DW:0] s_sh;
        assign s_sh = {r_rem[k-1], 1'b0};

        always_ff @(posedge i_clk) begin
            r_sat[k] <= r_sat[k-1];
            r_den[k] <= r_den[k-1];
            if (s_sh >= (DW+1)'(r_den[k-1])) begin
                r_rem[k] <= DW'(s_sh - (DW+1)'(r_den[k-1]));
                r_q[k]   <= {r_q[k-1][NQ-2:0], 1'b1};
            end else begin
                r_rem[k] <= DW'(s_sh);
                r_q[k]   <= {r_q[k-1][NQ-2:0], 1'b0};
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_side[k] <= '0;
            end else begin
                r_side[k] <= r_side[k-1];
            end
        end
    end

    assign o_side  = r_side[NQ];
    assign o_ratio = r_sat[NQ] ? trhc_pkg::Q_ONE : {1'b0, r_q[NQ]};

endmodule

>>> design/trhc_acos.sv
// ----------------------------------------------------------------------------
// trhc_acos: pipelined arc cosine search
// Binary search over 0..18000 hundredths of a degree, one level per cosine
// pipeline, then a nearest-value pick between the two bracketing angles.
// ----------------------------------------------------------------------------
module trhc_acos (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  trhc_pkg::t_side                i_side,
    input  logic [trhc_pkg::RATIO_W-1:0]   i_ratio,
    output trhc_pkg::t_side                o_side,
    output logic [trhc_pkg::MAG_W-1:0]     o_theta
);

    localparam int NL = trhc_pkg::ACOS_STEPS;
    localparam int NC = trhc_pkg::COS_LAT;
    localparam int MW = trhc_pkg::MAG_W;
    localparam int CW = trhc_pkg::COS_W;

    typedef struct packed {
        logic [MW-1:0]                   lo;
        logic [MW-1:0]                   hi;
        logic [MW-1:0]                   mid;
        logic signed [CW-1:0]            chi;    // cos(hi)
        logic signed [CW-1:0]            clm1;   // cos(lo - 1)
        logic [trhc_pkg::RATIO_W-1:0]    ratio;
    } t_srch;

    t_srch           r_lv   [NL+1];
    trhc_pkg::t_side r_slv  [NL+1];
    t_srch           r_dl   [NL][NC];
    trhc_pkg::t_side r_sdl  [NL][NC];

    logic signed [CW+2:0] s_dlo;
    logic signed [CW+2:0] s_dhi;
    logic                 s_pick;
    t_srch                s_last;

    always_ff @(posedge i_clk) begin
        r_lv[0].lo    <= '0;
        r_lv[0].hi    <= trhc_pkg::HALF_TURN;
        r_lv[0].mid   <= trhc_pkg::QUARTER_TURN;
        r_lv[0].chi   <= -$signed({1'b0, trhc_pkg::Q_ONE});
        r_lv[0].clm1  <= '0;
        r_lv[0].ratio <= i_ratio;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slv[0] <= '0;
        end else begin
            r_slv[0] <= i_side;
        end
    end

    for (genvar j = 0; j < NL; j++) begin : g_lvl
        logic signed [CW-1:0] s_cos;
        t_srch                s_cur;
        t_srch                s_nxt;
        logic [MW:0]          s_sum;

        trhc_cos u_cos (
            .i_clk   (i_clk),
            .i_angle (r_lv[j].mid),
            .o_cos   (s_cos)
        );

        always_ff @(posedge i_clk) begin
            r_dl[j][0] <= r_lv[j];
            for (int i = 1; i < NC; i++) begin
                r_dl[j][i] <= r_dl[j][i-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                for (int i = 0; i < NC; i++) begin
                    r_sdl[j][i] <= '0;
                end
                r_slv[j+1] <= '0;
            end else begin
                r_sdl[j][0] <= r_slv[j];
                for (int i = 1; i < NC; i++) begin
                    r_sdl[j][i] <= r_sdl[j][i-1];
                end
                r_slv[j+1] <= r_sdl[j][NC-1];
            end
        end

        always_comb begin
            s_cur = r_dl[j][NC-1];
            s_nxt = s_cur;
            if (s_cur.lo < s_cur.hi) begin
                if (s_cos <= $signed({2'b00, s_cur.ratio})) begin
                    s_nxt.hi  = s_cur.mid;
                    s_nxt.chi = s_cos;
                end else begin
                    s_nxt.lo   = s_cur.mid + MW'(1);
                    s_nxt.clm1 = s_cos;
                end
            end
            s_sum     = (MW+1)'(s_nxt.lo) + (MW+1)'(s_nxt.hi);
            s_nxt.mid = s_sum[MW:1];
        end

        always_ff @(posedge i_clk) begin
            r_lv[j+1] <= s_nxt;
        end
    end

    // ties go to the smaller angle
    always_comb begin
        s_last = r_lv[NL];
        s_dlo  = (CW+3)'(s_last.clm1) - $signed({3'b000, s_last.ratio});
        s_dhi  = $signed({3'b000, s_last.ratio}) - (CW+3)'(s_last.chi);
        s_pick = (s_last.lo != '0) && (s_dlo <= s_dhi);
    end

    always_ff @(posedge i_clk) begin
        o_theta <= s_pick ? s_last.lo - MW'(1) : s_last.lo;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_side <= '0;
        end else begin
            o_side <= r_slv[NL];
        end
    end

endmodule

>>> tb/tb_two_ray_heading_correction.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_two_ray_heading_correction: self-checking bench for the heading block
// Drives reading pairs through the command port with random gaps, writes the
// sensor angle between phases and checks every strobed result against an
// integer model of the cosine, square root, divide and arc cosine datapath.
// ----------------------------------------------------------------------------
module tb_two_ray_heading_correction;

    localparam int  CYCLE_LIMIT = 200000;
    localparam int  DRAIN_WAIT  = 420;
    localparam longint QONE     = 64'sd1 << 30;

    typedef struct {
        logic signed [trhc_pkg::OUT_W-1:0] turn;
        logic                              degen;
    } t_heading;

    logic                                  i_clk;
    logic                                  i_rst_n;
    logic                                  i_start;
    logic                                  o_busy;
    logic [trhc_pkg::DIST_BITS-1:0]        i_left_distance;
    logic [trhc_pkg::DIST_BITS-1:0]        i_right_distance;
    logic                                  i_cfg_valid;
    logic                                  o_cfg_ready;
    logic [trhc_pkg::ANG_W-1:0]            i_sensor_angle;
    logic                                  o_valid;
    logic signed [trhc_pkg::OUT_W-1:0]     o_turn_angle;
    logic                                  o_degenerate;

    logic                                  busy_lo;
    logic                                  ready_lo;
    logic [trhc_pkg::ANG_W-1:0]            angle_reg;
    t_heading                              heading_q[$];
    int                                    mismatches;
    int                                    cycles;

    two_ray_heading_correction u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_start          (i_start),
        .o_busy           (o_busy),
        .i_left_distance  (i_left_distance),
        .i_right_distance (i_right_distance),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_sensor_angle   (i_sensor_angle),
        .o_valid          (o_valid),
        .o_turn_angle     (o_turn_angle),
        .o_degenerate     (o_degenerate)
    );

    always begin
        i_clk = 1'b1;
        #2;
        i_clk = 1'b0;
        #2;
    end

    // handshake inputs are settled in the low phase
    always @(negedge i_clk) begin
        busy_lo  <= o_busy;
        ready_lo <= o_cfg_ready;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // ---------------- integer model ----------------
    function automatic longint cos_q30(int d);
        bit [63:0] m, x, x2, t;
        bit [63:0] dens[5];
        longint    c;
        bit        neg;
        dens = '{64'd132, 64'd90, 64'd56, 64'd30, 64'd12};
        neg  = 1'b0;
        m = (d < 0) ? 64'(-d) : 64'(d);
        m = m % 36000;
        if (m > 18000) m = 36000 - m;
        if (m > 9000) begin
            m   = 18000 - m;
            neg = 1'b1;
        end
        x  = (m * 64'd3373259426 + 64'd9000) / 64'd18000;
        x2 = (x * x) >> 30;
        t  = 64'(QONE);
        for (int i = 0; i < 5; i++) t = 64'(QONE) - ((x2 * t) >> 30) / dens[i];
        c = QONE - longint'(((x2 * t) >> 30) / 64'd2);
        return neg ? -c : c;
    endfunction

    function automatic int acos_units(longint r);
        int lo, hi, mid;
        lo = 0;
        hi = 18000;
        while (lo < hi) begin
            mid = (lo + hi) / 2;
            if (cos_q30(mid) <= r) hi = mid;
            else lo = mid + 1;
        end
        if (lo > 0 && cos_q30(lo - 1) - r <= r - cos_q30(lo)) lo = lo - 1;
        return lo;
    endfunction

    function automatic bit [63:0] floor_sqrt(bit [63:0] v);
        bit [63:0] res, b;
        res = 0;
        b   = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v   = v - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic longint frac_q30(bit [63:0] n, bit [63:0] d);
        bit [63:0] q, r;
        if (n >= d) return QONE;
        q = 0;
        r = n;
        for (int i = 0; i < 30; i++) begin
            r = r << 1;
            q = q << 1;
            if (r >= d) begin
                r = r - d;
                q = q | 64'd1;
            end
        end
        return longint'(q);
    endfunction

    function automatic t_heading heading_of(bit [trhc_pkg::DIST_BITS-1:0] lft,
                                            bit [trhc_pkg::DIST_BITS-1:0] rgt);
        bit [63:0] l, r, lng, sht, mag, root, den;
        longint    cosv, twoabc, c2, num, ratio;
        int        ang, res;
        t_heading  h;
        l   = 64'(lft);
        r   = 64'(rgt);
        ang = int'(angle_reg);
        res = 0;
        h.degen = 1'b0;
        if (l != 0 || r != 0) begin
            cosv   = cos_q30(18000 - 2 * ang);
            mag    = l * r * 64'(cosv < 0 ? -cosv : cosv);
            twoabc = longint'((mag + 64'd4096) >> 13);
            if (cosv < 0) twoabc = -twoabc;
            c2 = longint'((l * l + r * r) << 16) - twoabc;
            if (c2 < 0) c2 = 0;
            root = floor_sqrt(64'(c2));
            if (root == 0) begin
                h.degen = 1'b1;
            end else begin
                if (r > l) begin
                    lng = r;
                    sht = l;
                end else begin
                    lng = l;
                    sht = r;
                end
                num   = longint'((lng * lng) << 16) + c2 - longint'((sht * sht) << 16);
                den   = (64'd2 * lng * root) << 8;
                ratio = frac_q30(64'(num < 0 ? -num : num), den);
                if (num < 0) ratio = -ratio;
                res = ang - acos_units(ratio);
                if (r > l) res = -res;
            end
        end
        h.turn = trhc_pkg::OUT_W'(res);
        return h;
    endfunction

    // ---------------- result check ----------------
    always @(posedge i_clk) begin
        t_heading want;
        if (i_rst_n && o_valid) begin
            if (heading_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result turn=%0d degen=%0b", o_turn_angle, o_degenerate);
            end else begin
                want = heading_q.pop_front();
                if (o_turn_angle !== want.turn || o_degenerate !== want.degen) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp turn=%0d degen=%0b, got turn=%0d degen=%0b",
                                 want.turn, want.degen, o_turn_angle, o_degenerate);
                end
            end
        end
    end

    // ---------------- drivers ----------------
    task automatic send_reading(bit [trhc_pkg::DIST_BITS-1:0] lft,
                                bit [trhc_pkg::DIST_BITS-1:0] rgt);
        int gap;
        gap = $urandom_range(0, 11);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap > 0) begin
            i_start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_start          <= 1'b1;
        i_left_distance  <= lft;
        i_right_distance <= rgt;
        do @(posedge i_clk); while (busy_lo);
        heading_q.push_back(heading_of(lft, rgt));
    endtask

    task automatic drain;
        i_start <= 1'b0;
        while (heading_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_angle(bit [trhc_pkg::ANG_W-1:0] a);
        drain();
        i_cfg_valid    <= 1'b1;
        i_sensor_angle <= a;
        do @(posedge i_clk); while (!ready_lo);
        i_cfg_valid <= 1'b0;
        angle_reg = a;
    endtask

    function automatic bit [trhc_pkg::DIST_BITS-1:0] rand_dist();
        case ($urandom_range(0, 5))
            0: return trhc_pkg::DIST_BITS'($urandom_range(0, 15));
            1: return {trhc_pkg::DIST_BITS{1'b1}} - trhc_pkg::DIST_BITS'($urandom_range(0, 15));
            default: return trhc_pkg::DIST_BITS'($urandom);
        endcase
    endfunction

    // ---------------- tests ----------------
    task automatic test_directed;
        send_reading(0, 0);
        send_reading(4095, 4095);
        send_reading(4095, 0);
        send_reading(0, 4095);
        send_reading(1, 1);
        send_reading(1000, 1000);
        send_reading(1000, 1001);
        send_reading(1001, 1000);
        send_reading(1, 4095);
        send_reading(4095, 1);
        send_reading(2730, 1365);
        send_reading(1365, 2730);
        // rays straight ahead: apex of 180 degrees, third side is the sum
        write_angle(0);
        send_reading(500, 500);
        send_reading(0, 0);
        send_reading(700, 300);
        // rays sideways: zero apex, equal readings give a third side of zero
        write_angle(9000);
        send_reading(1200, 800);
        send_reading(800, 1200);
        send_reading(4095, 4095);
        write_angle({trhc_pkg::ANG_W{1'b1}});
        send_reading(3000, 100);
        send_reading(100, 3000);
        send_reading(2048, 2048);
    endtask

    task automatic test_random_phase(bit [trhc_pkg::ANG_W-1:0] a, int count);
        bit [trhc_pkg::DIST_BITS-1:0] l, r;
        write_angle(a);
        for (int i = 0; i < count; i++) begin
            l = rand_dist();
            r = rand_dist();
            if ($urandom_range(0, 7) == 0) r = l;
            else if ($urandom_range(0, 7) == 0)
                r = l + trhc_pkg::DIST_BITS'($urandom_range(0, 3));
            if ($urandom_range(0, 31) == 0) begin
                l = 0;
                r = 0;
            end
            send_reading(l, r);
        end
    endtask

    initial begin
        i_rst_n          = 1'b0;
        i_start          = 1'b0;
        i_left_distance  = '0;
        i_right_distance = '0;
        i_cfg_valid      = 1'b0;
        i_sensor_angle   = '0;
        busy_lo          = 1'b1;
        ready_lo         = 1'b0;
        angle_reg        = trhc_pkg::ANGLE_RESET;
        mismatches       = 0;
        cycles           = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_random_phase(4500, 250);
        test_random_phase(0, 150);
        test_random_phase(9000, 200);
        test_random_phase(trhc_pkg::ANG_W'($urandom_range(1, 8999)), 250);
        test_random_phase(trhc_pkg::ANG_W'($urandom_range(9001, 16383)), 150);
        test_random_phase(trhc_pkg::ANG_W'($urandom), 150);
        test_random_phase(1, 150);

        drain();
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (mismatches == 0 && heading_q.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule
